// ===== hdl/tccs_pkg.sv =====
// Shared constants, types and address helpers of the text console cursor and scroll engine.
package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);

  localparam int ROW_FW  = 5;
  localparam int COL_FW  = 7;
  localparam int CHAR_FW = 8;
  localparam int CELL_W  = 16;

  localparam logic [CHAR_FW-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0F20;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        char_code;
    logic [7:0]        color;
    logic [ROW_FW-1:0] read_row;
    logic [COL_FW-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_FW-1:0] cursor_row;
    logic [COL_FW-1:0] cursor_col;
    logic              scrolled;
  } result_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } mem_req_t;

  // Map a screen row to its slot in the row ring.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] prow,
                                                  input logic [CW-1:0] col);
    return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

endpackage

// ===== hdl/tccs_if.sv =====
// Handshake channel interfaces for console put/read words and result words.
interface tccs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;
  logic [7:0] color;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, output op, output char_code, output color,
                  output read_row, output read_col, input ready);
  modport sink   (input valid, input op, input char_code, input color,
                  input read_row, input read_col, output ready);
endinterface

interface tccs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic        scrolled;

  modport source (output valid, output cell_value, output cursor_row,
                  output cursor_col, output scrolled, input ready);
  modport sink   (input valid, input cell_value, input cursor_row,
                  input cursor_col, input scrolled, output ready);
endinterface

// ===== hdl/tccs_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tccs_ctrl.sv =====
// Sequencer: cursor, row ring, lazy row clear, cell access and result register.
module tccs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tccs_pkg::item_t           in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tccs_pkg::result_t         out_res_o,
  output tccs_pkg::mem_req_t        mem_req_o,
  input  logic [tccs_pkg::CELL_W-1:0] mem_rdata_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_CLEAR  = 2'd2;
  localparam logic [1:0] ST_RDWAIT = 2'd3;

  localparam logic [tccs_pkg::RW-1:0] ROW_LAST = tccs_pkg::RW'(tccs_pkg::ROWS - 1);
  localparam logic [tccs_pkg::CW-1:0] COL_LAST = tccs_pkg::CW'(tccs_pkg::COLUMNS - 1);

  logic [1:0]                  state_q, state_d;
  tccs_pkg::item_t             item_q;
  logic [tccs_pkg::RW-1:0]     cur_row_q, cur_row_d;
  logic [tccs_pkg::CW-1:0]     cur_col_q, cur_col_d;
  logic [tccs_pkg::RW-1:0]     top_q, top_d;
  logic [tccs_pkg::ROWS-1:0]   row_valid_q, row_valid_d;
  logic [tccs_pkg::CW-1:0]     clr_col_q, clr_col_d;
  logic                        rd_hit_q, rd_hit_d;
  logic                        rd_valid_q, rd_valid_d;
  logic                        out_valid_q, out_valid_d;
  tccs_pkg::result_t           out_res_q, out_res_d;

  logic                        slot_free;
  logic [tccs_pkg::RW-1:0]     cur_prow;
  logic [tccs_pkg::RW-1:0]     rd_prow;
  logic                        rd_in_range;
  logic                        newline;
  logic                        row_adv;
  logic                        row_last;
  logic [tccs_pkg::RW-1:0]     top_next;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign cur_prow    = tccs_pkg::phys_row(cur_row_q, top_q);
  assign rd_in_range = (32'(item_q.read_row) < 32'(tccs_pkg::ROWS)) &&
                       (32'(item_q.read_col) < 32'(tccs_pkg::COLUMNS));
  assign rd_prow     = tccs_pkg::phys_row(tccs_pkg::RW'(item_q.read_row), top_q);
  assign newline     = (item_q.char_code == tccs_pkg::NEWLINE_CODE);
  assign row_adv     = newline || (cur_col_q == COL_LAST);
  assign row_last    = (cur_row_q == ROW_LAST);
  assign top_next    = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    top_d       = top_q;
    row_valid_d = row_valid_q;
    clr_col_d   = clr_col_q;
    rd_hit_d    = rd_hit_q;
    rd_valid_d  = rd_valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    mem_req_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_q.op == tccs_pkg::OP_READ) begin
          // Issue the read; out-of-range reads skip the memory.
          mem_req_o.en   = rd_in_range;
          mem_req_o.addr = tccs_pkg::cell_addr(rd_prow, tccs_pkg::CW'(item_q.read_col));
          rd_hit_d       = rd_in_range;
          rd_valid_d     = row_valid_q[rd_prow];
          state_d        = ST_RDWAIT;
        end else if (!newline && !row_valid_q[cur_prow]) begin
          // Row never written since reset or scroll: blank it first.
          clr_col_d = '0;
          state_d   = ST_CLEAR;
        end else if (slot_free) begin
          if (!newline) begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = tccs_pkg::cell_addr(cur_prow, cur_col_q);
            mem_req_o.wdata = {item_q.color, item_q.char_code};
          end
          cur_col_d = row_adv ? '0 : cur_col_q + 1'b1;
          if (row_adv && !row_last) begin
            cur_row_d = cur_row_q + 1'b1;
          end
          if (row_adv && row_last) begin
            // Old top slot becomes the new bottom row; drop its contents.
            row_valid_d[top_q] = 1'b0;
            top_d              = top_next;
          end
          out_valid_d          = 1'b1;
          out_res_d.cell_value = '0;
          out_res_d.cursor_row = tccs_pkg::ROW_FW'(cur_row_d);
          out_res_d.cursor_col = tccs_pkg::COL_FW'(cur_col_d);
          out_res_d.scrolled   = row_adv && row_last;
          state_d              = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        mem_req_o.en    = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = tccs_pkg::cell_addr(cur_prow, clr_col_q);
        mem_req_o.wdata = tccs_pkg::BLANK_CELL;
        clr_col_d       = clr_col_q + 1'b1;
        if (clr_col_q == COL_LAST) begin
          row_valid_d[cur_prow] = 1'b1;
          state_d               = ST_EXEC;
        end
      end
      ST_RDWAIT: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_res_d.cell_value = !rd_hit_q   ? '0 :
                                 !rd_valid_q ? tccs_pkg::BLANK_CELL : mem_rdata_i;
          out_res_d.cursor_row = tccs_pkg::ROW_FW'(cur_row_q);
          out_res_d.cursor_col = tccs_pkg::COL_FW'(cur_col_q);
          out_res_d.scrolled   = 1'b0;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      top_q       <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      top_q       <= top_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_item_i;
    end
    clr_col_q  <= clr_col_d;
    rd_hit_q   <= rd_hit_d;
    rd_valid_q <= rd_valid_d;
    out_res_q  <= out_res_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== hdl/text_console_cursor_scroll.sv =====
// Top level of the text console engine: screen RAM, sequencer and channel ports.
//
//   channel  dir  word contents
//   -------  ---  ---------------------------------------------------------
//   in_i     in   op, char_code, color, read_row, read_col
//   out_o    out  cell_value, cursor_row, cursor_col, scrolled
//
// A put word is accepted, then executed; a read word adds a wait state for the
// registered read of the single-port screen RAM. A scroll only advances the
// top-row pointer of the row ring; the first character put into an empty row
// blanks it first, one cell per cycle, in a clear state between two execute steps.
// Reset clears cursor, ring pointer and row-valid flags; empty rows read blank.
// The next word is accepted while a result waits; hold only when a new one is due.
module text_console_cursor_scroll (
  input  logic              clk_i,
  input  logic              rst_ni,
  tccs_in_if.sink           in_i,
  tccs_out_if.source        out_o
);

  tccs_pkg::item_t                  in_item;
  tccs_pkg::result_t                out_res;
  tccs_pkg::mem_req_t               mem_req;
  logic [tccs_pkg::CELL_W-1:0]      mem_rdata;

  // Pack the incoming word.
  always_comb begin
    in_item.op        = tccs_pkg::op_e'(in_i.op);
    in_item.char_code = in_i.char_code;
    in_item.color     = in_i.color;
    in_item.read_row  = in_i.read_row;
    in_item.read_col  = in_i.read_col;
  end

  tccs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Screen store: one cell per address, row slot major.
  tccs_ram #(
    .WIDTH (tccs_pkg::CELL_W),
    .DEPTH (tccs_pkg::CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  // Unpack the result word.
  assign out_o.cell_value = out_res.cell_value;
  assign out_o.cursor_row = out_res.cursor_row;
  assign out_o.cursor_col = out_res.cursor_col;
  assign out_o.scrolled   = out_res.scrolled;

endmodule

// ===== hdl/tccs_checker.sv =====
// Port-level checks of the text console engine and their binding.
module tccs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] cell_value_i,
  input logic [4:0]  cursor_row_i,
  input logic [6:0]  cursor_col_i,
  input logic        scrolled_i
);

  // One word at a time: the input closes right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  // A scroll leaves the cursor on the bottom row and carries no cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && scrolled_i |->
      cell_value_i == 16'h0 && cursor_row_i == 5'(tccs_pkg::ROWS - 1))
    else $error("scroll result with wrong row or cell");

  // Cursor column stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(cursor_col_i) < 32'(tccs_pkg::COLUMNS) ||
                    tccs_pkg::COLUMNS > 128)
    else $error("cursor column beyond row end");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(cell_value_i) && $stable(cursor_row_i) &&
      $stable(cursor_col_i) && $stable(scrolled_i))
    else $error("stalled result word changed");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .cell_value_i (out_o.cell_value),
  .cursor_row_i (out_o.cursor_row),
  .cursor_col_i (out_o.cursor_col),
  .scrolled_i   (out_o.scrolled)
);
